// File: src/frg_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Frame rate gate classifier package
// Shared widths, reset values, codes and bundles for the classifier core.
// ----------------------------------------------------------------------------
package frg_pkg;

  // Field widths.
  localparam int unsigned TimeW   = 63;
  localparam int unsigned GapW    = 27;
  localparam int unsigned CountW  = 7;
  localparam int unsigned RunW    = 5;
  localparam int unsigned ActionW = 2;
  localparam int unsigned CfgIdxW = 3;

  // Sample count saturates here.
  localparam logic [CountW-1:0] SAMPLE_CAP = 7'd120;
  localparam logic [RunW-1:0]   RUN_MAX    = 5'd31;

  // Register reset values.
  localparam logic [GapW-1:0]   MIN_GAP_RESET        = 27'd4000000;
  localparam logic [GapW-1:0]   MAX_GAP_RESET        = 27'd100000000;
  localparam logic [GapW-1:0]   HIGH_RATE_GAP_RESET  = 27'd30000000;
  localparam logic [GapW-1:0]   SLOW_GAP_RESET       = 27'd31500000;
  localparam logic [CountW-1:0] MIN_SAMPLES_RESET    = 7'd8;
  localparam logic [RunW-1:0]   SLOW_RUN_LIMIT_RESET = 5'd16;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_MIN_GAP        = 3'd0,
    CFG_MAX_GAP        = 3'd1,
    CFG_HIGH_RATE_GAP  = 3'd2,
    CFG_SLOW_GAP       = 3'd3,
    CFG_MIN_SAMPLES    = 3'd4,
    CFG_SLOW_RUN_LIMIT = 3'd5
  } cfg_idx_t;

  // Rate decision held between presents.
  typedef enum logic [1:0] {
    DEC_UND  = 2'd0,
    DEC_GEN  = 2'd1,
    DEC_PASS = 2'd2
  } dec_t;

  // Action reported for each present.
  typedef enum logic [ActionW-1:0] {
    ACT_NORMAL  = 2'd0,
    ACT_MEASURE = 2'd1,
    ACT_PASS    = 2'd2,
    ACT_GEN     = 2'd3
  } action_t;

  // Configuration bundle.
  typedef struct packed {
    logic [GapW-1:0]   min_gap_ns;
    logic [GapW-1:0]   max_gap_ns;
    logic [GapW-1:0]   high_rate_gap_ns;
    logic [GapW-1:0]   slow_gap_ns;
    logic [CountW-1:0] min_samples;
    logic [RunW-1:0]   slow_run_limit;
  } cfg_t;

  // Rate tracking state.
  typedef struct packed {
    logic [TimeW-1:0]  last_time;
    logic [GapW-1:0]   avg_gap;
    logic [CountW-1:0] samples;
    logic [RunW-1:0]   slow_run;
    dec_t              decision;
    logic              prev_enabled;
  } track_t;

  // One result transaction.
  typedef struct packed {
    action_t           action;
    logic [GapW-1:0]   gap_ns;
    logic [GapW-1:0]   average_gap_ns;
    logic [CountW-1:0] sample_count;
  } result_t;

  localparam track_t TRACK_CLEAR = '{
    last_time:    '0,
    avg_gap:      '0,
    samples:      '0,
    slow_run:     '0,
    decision:     DEC_UND,
    prev_enabled: 1'b0
  };

endpackage
`default_nettype wire

// File: src/frame_rate_gate_classifier_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Frame rate gate classifier core
// Classifies frame-present events by their measured rate and reports the
// gap, running average, sample count and chosen action for each present.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one present per transaction:
//   time_ns, gen_enabled and compatible. Output channel (out_valid /
//   out_stall) returns exactly one result transaction per present, in order.
//   Configuration registers are written through cfg_we / cfg_index /
//   cfg_data; the user must write them only while the block is idle (the
//   block does not enforce this); writes take effect on the next present.
//   An accepted present waits in the input register, and its result is
//   then registered in the output register. Throughput: one present per
//   cycle while out_stall is low; the tracking state is updated
//   combinationally between the input register and the output register.
//   When the receiver stalls, the result holds in the output register and
//   one more present can wait in the input register; in_stall rises only when both are full.
//   Synchronous reset clears all tracking state, empties both registers and
//   loads every configuration register with its default value.
// ----------------------------------------------------------------------------
module frame_rate_gate_classifier_core import frg_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  // Configuration write port.
  input  wire logic               cfg_we,
  input  wire logic [CfgIdxW-1:0] cfg_index,
  input  wire logic [GapW-1:0]    cfg_data,
  // Present input channel.
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [TimeW-1:0]   time_ns,
  input  wire logic               gen_enabled,
  input  wire logic               compatible,
  // Result output channel.
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [ActionW-1:0]      action,
  output logic [GapW-1:0]         gap_ns,
  output logic [GapW-1:0]         average_gap_ns,
  output logic [CountW-1:0]       sample_count
);

  cfg_t    cfg;
  track_t  track;
  track_t  track_next;
  result_t res;

  logic             q_valid;
  logic [TimeW-1:0] q_time;
  logic             q_enabled;
  logic             q_compatible;
  logic             advance;
  logic             in_accept;

  frg_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  frg_step u_step (
    .cfg         (cfg),
    .st          (track),
    .time_ns     (q_time),
    .gen_enabled (q_enabled),
    .compatible  (q_compatible),
    .st_next     (track_next),
    .res         (res)
  );

  // Handshake: the held present moves on when the output register is free.
  assign advance   = !out_valid || !out_stall;
  assign in_stall  = q_valid && !advance;
  assign in_accept = in_valid && !in_stall;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (in_accept) begin
      q_valid <= 1'b1;
    end else if (advance) begin
      q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      q_time       <= time_ns;
      q_enabled    <= gen_enabled;
      q_compatible <= compatible;
    end
  end

  // Tracking state and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      track     <= TRACK_CLEAR;
      out_valid <= 1'b0;
    end else if (q_valid && advance) begin
      track     <= track_next;
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_valid && advance) begin
      action         <= res.action;
      gap_ns         <= res.gap_ns;
      average_gap_ns <= res.average_gap_ns;
      sample_count   <= res.sample_count;
    end
  end

endmodule
`default_nettype wire

// File: src/frg_cfg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Frame rate gate configuration registers
// Holds the gap window, rate thresholds and count limits, written by index.
// ----------------------------------------------------------------------------
module frg_cfg import frg_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_we,
  input  wire logic [CfgIdxW-1:0] cfg_index,
  input  wire logic [GapW-1:0]    cfg_data,
  output cfg_t                    cfg
);

  // Register file; values are kept masked to each register's width.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_gap_ns       <= MIN_GAP_RESET;
      cfg.max_gap_ns       <= MAX_GAP_RESET;
      cfg.high_rate_gap_ns <= HIGH_RATE_GAP_RESET;
      cfg.slow_gap_ns      <= SLOW_GAP_RESET;
      cfg.min_samples      <= MIN_SAMPLES_RESET;
      cfg.slow_run_limit   <= SLOW_RUN_LIMIT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_MIN_GAP:        cfg.min_gap_ns       <= cfg_data;
        CFG_MAX_GAP:        cfg.max_gap_ns       <= cfg_data;
        CFG_HIGH_RATE_GAP:  cfg.high_rate_gap_ns <= cfg_data;
        CFG_SLOW_GAP:       cfg.slow_gap_ns      <= cfg_data;
        CFG_MIN_SAMPLES:    cfg.min_samples      <= cfg_data[CountW-1:0];
        CFG_SLOW_RUN_LIMIT: cfg.slow_run_limit   <= cfg_data[RunW-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// File: src/frg_step.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Frame rate gate update logic
// Computes the gap, average, sample count, decision and action for one
// present, together with the next tracking state.
// ----------------------------------------------------------------------------
module frg_step import frg_pkg::*; (
  input  wire cfg_t              cfg,
  input  wire track_t            st,
  input  wire logic [TimeW-1:0]  time_ns,
  input  wire logic              gen_enabled,
  input  wire logic              compatible,
  output track_t                 st_next,
  output result_t                res
);

  // High rate when enough samples exist and the average is nonzero and below threshold.
  function automatic dec_t rate_decide(input cfg_t c, input track_t s);
    logic high;
    high = (s.samples >= c.min_samples) && (s.avg_gap != '0) &&
           (s.avg_gap < c.high_rate_gap_ns);
    return high ? DEC_PASS : DEC_GEN;
  endfunction

  logic [TimeW-1:0] gap_full;
  logic             has_gap;
  logic             in_window;
  logic             observed;
  logic [GapW:0]    avg_sum;

  // Gap measurement against the previous present.
  always_comb begin
    observed  = compatible && (!gen_enabled || st.decision != DEC_GEN);
    has_gap   = (st.last_time != '0) && (time_ns > st.last_time);
    gap_full  = time_ns - st.last_time;
    in_window = has_gap && (gap_full >= TimeW'(cfg.min_gap_ns)) &&
                (gap_full <= TimeW'(cfg.max_gap_ns));
    // Window bounds fit in GapW bits, so the low bits are the whole gap.
    avg_sum   = {1'b0, st.avg_gap} - {4'b0, st.avg_gap[GapW-1:3]} +
                {4'b0, gap_full[GapW-1:3]};
  end

  track_t          s;
  logic [GapW-1:0] gap;
  action_t         action;

  // Ordered combinational update of the tracking state for this present.
  always_comb begin
    s      = st;
    gap    = '0;
    action = ACT_NORMAL;

    // Observation: accept an in-window gap into the average and store the timestamp.
    if (observed) begin
      if (in_window) begin
        gap = gap_full[GapW-1:0];
        if (st.samples == '0) begin
          s.avg_gap = gap_full[GapW-1:0];
        end else begin
          s.avg_gap = avg_sum[GapW-1:0];
        end
        if (st.samples < SAMPLE_CAP) begin
          s.samples = st.samples + 1'b1;
        end
      end
      s.last_time = time_ns;
    end

    // Enable change seen on a compatible present.
    if (compatible && (gen_enabled != st.prev_enabled)) begin
      if (gen_enabled) begin
        s.decision     = (s.samples >= cfg.min_samples) ? rate_decide(cfg, s) : DEC_UND;
        s.slow_run     = '0;
        s.prev_enabled = 1'b1;
      end else begin
        s = TRACK_CLEAR;
      end
    end

    // Classification of this present.
    if (gen_enabled && compatible) begin
      if (s.decision == DEC_UND && s.samples >= cfg.min_samples) begin
        s.decision = rate_decide(cfg, s);
      end
      action = ACT_GEN;
      if (s.decision == DEC_PASS) begin
        if (gap >= cfg.slow_gap_ns) begin
          if (s.slow_run < RUN_MAX) begin
            s.slow_run = s.slow_run + 1'b1;
          end
        end else if (gap != '0) begin
          s.slow_run = '0;
        end
        if (s.slow_run < cfg.slow_run_limit) begin
          action = ACT_PASS;
        end else begin
          s.decision = DEC_GEN;
          s.slow_run = '0;
        end
      end else if (s.decision == DEC_UND) begin
        action = ACT_MEASURE;
      end
    end
  end

  // Result and next state.
  always_comb begin
    st_next            = s;
    res.action         = action;
    res.gap_ns         = gap;
    res.average_gap_ns = s.avg_gap;
    res.sample_count   = s.samples;
  end

endmodule
`default_nettype wire
